/* hw/rtl/load_cell_adc_serial_reader_core_macros.svh */
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_core_macros
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_ADC_SERIAL_READER_CORE_MACROS_SVH
`define LOAD_CELL_ADC_SERIAL_READER_CORE_MACROS_SVH

// checked only out of reset
`define LCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/lcr_pkg.sv */
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants for the load-cell serial reader.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int LCR_DATA_BITS   = 24;
  localparam int LCR_MAX_SAMPLES = 255;
  localparam int LCR_AVG_W       = 24;
  localparam int LCR_CFG_W       = 8;
  localparam int LCR_IDX_W       = 1;

  localparam logic [LCR_AVG_W-1:0] LCR_OFFSET = 24'h800000;

  typedef enum logic [LCR_IDX_W-1:0] {
    REG_EXTRA_PULSES = 1'b0,
    REG_SAMPLE_COUNT = 1'b1
  } lcr_reg_t;

  // per-tick control handed from front to back
  typedef struct packed {
    logic clk_level;
    logic avg_valid;
  } lcr_ctl_t;

endpackage

/* hw/rtl/lcr_front.sv */
// ----------------------------------------------------------------------------
// lcr_front
// Tick sequencer: drives the serial clock, shifts in data bits, accumulates
// readings and pushes one request per tick into the queue.
// ----------------------------------------------------------------------------
module lcr_front import lcr_pkg::*; #(
  parameter int DATA_BITS   = LCR_DATA_BITS,
  parameter int MAX_SAMPLES = LCR_MAX_SAMPLES,
  parameter int RW          = (DATA_BITS > LCR_AVG_W) ? DATA_BITS : LCR_AVG_W,
  parameter int CW          = $clog2(MAX_SAMPLES + 1),
  parameter int SW          = RW + CW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [LCR_IDX_W-1:0] cfg_index,
  input  logic [LCR_CFG_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_data_pin,
  input  logic                 q_full,
  output logic                 q_push,
  output lcr_ctl_t             q_ctl,
  output logic [SW-1:0]        q_sum,
  output logic [CW-1:0]        q_cnt
);

  localparam int BW = $clog2(DATA_BITS + 1);

  typedef enum logic [2:0] {
    PH_WAIT, PH_DATA_HI, PH_DATA_LO, PH_EXTRA_HI, PH_EXTRA_LO
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;
  logic [1:0]           pulse_r, pulse_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [CW-1:0]        done_r, done_nxt;
  logic [SW-1:0]        sum_r, sum_nxt;
  logic [1:0]           extra_r;
  logic [LCR_CFG_W-1:0] count_r;

  logic [1:0]    need;
  logic [CW-1:0] eff;
  logic [RW-1:0] reading;
  logic [SW-1:0] sum_add;
  logic [CW-1:0] done_inc;

  assign in_ready = ~q_full;
  assign q_push   = in_valid & in_ready;

  assign need     = (extra_r == 2'd0) ? 2'd1 : extra_r;
  assign eff      = (count_r == '0) ? CW'(1) :
                    (count_r > LCR_CFG_W'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) :
                    count_r[CW-1:0];
  assign reading  = RW'(shift_r) ^ RW'(LCR_OFFSET);
  assign sum_add  = sum_r + SW'(reading);
  assign done_inc = done_r + CW'(1);

  always_comb begin
    phase_nxt       = phase_r;
    bit_nxt         = bit_r;
    pulse_nxt       = pulse_r;
    shift_nxt       = shift_r;
    done_nxt        = done_r;
    sum_nxt         = sum_r;
    q_ctl.clk_level = 1'b0;
    q_ctl.avg_valid = 1'b0;
    q_sum           = sum_add;
    q_cnt           = done_inc;
    unique case (phase_r)
      PH_WAIT: begin
        if (!in_data_pin) begin
          phase_nxt = PH_DATA_HI;
          bit_nxt   = '0;
          shift_nxt = '0;
        end
      end
      PH_DATA_HI: begin
        q_ctl.clk_level = 1'b1;
        phase_nxt       = PH_DATA_LO;
      end
      PH_DATA_LO: begin
        shift_nxt = {shift_r[DATA_BITS-2:0], in_data_pin};
        bit_nxt   = bit_r + BW'(1);
        if (bit_nxt >= BW'(DATA_BITS)) begin
          phase_nxt = PH_EXTRA_HI;
          pulse_nxt = '0;
        end else begin
          phase_nxt = PH_DATA_HI;
        end
      end
      PH_EXTRA_HI: begin
        q_ctl.clk_level = 1'b1;
        phase_nxt       = PH_EXTRA_LO;
      end
      PH_EXTRA_LO: begin
        pulse_nxt = pulse_r + 2'd1;
        if (pulse_nxt >= need) begin
          sum_nxt  = sum_add;
          done_nxt = done_inc;
          if (done_inc >= eff) begin
            q_ctl.avg_valid = 1'b1;
            sum_nxt         = '0;
            done_nxt        = '0;
          end
          pulse_nxt = '0;
          bit_nxt   = '0;
          phase_nxt = PH_WAIT;
        end else begin
          phase_nxt = PH_EXTRA_HI;
        end
      end
      default: phase_nxt = PH_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      bit_r   <= '0;
      pulse_r <= '0;
      shift_r <= '0;
      done_r  <= '0;
      sum_r   <= '0;
      extra_r <= 2'd1;
      count_r <= LCR_CFG_W'(1);
    end else begin
      if (q_push) begin
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        pulse_r <= pulse_nxt;
        shift_r <= shift_nxt;
        done_r  <= done_nxt;
        sum_r   <= sum_nxt;
      end
      if (cfg_we) begin
        unique case (lcr_reg_t'(cfg_index))
          REG_EXTRA_PULSES: extra_r <= cfg_wdata[1:0];
          REG_SAMPLE_COUNT: count_r <= cfg_wdata;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/lcr_queue.sv */
// ----------------------------------------------------------------------------
// lcr_queue
// Two-entry request queue between the tick sequencer and the divider.
// ----------------------------------------------------------------------------
module lcr_queue import lcr_pkg::*; #(
  parameter int SW = LCR_AVG_W + 8,
  parameter int CW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lcr_ctl_t      push_ctl,
  input  logic [SW-1:0] push_sum,
  input  logic [CW-1:0] push_cnt,
  output logic          full,
  output logic          head_valid,
  input  logic          pop,
  output lcr_ctl_t      head_ctl,
  output logic [SW-1:0] head_sum,
  output logic [CW-1:0] head_cnt
);

  lcr_ctl_t      ctl_mem_r [2];
  logic [SW-1:0] sum_mem_r [2];
  logic [CW-1:0] cnt_mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    fill_r;

  assign full       = (fill_r == 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign head_ctl   = ctl_mem_r[rd_ptr_r];
  assign head_sum   = sum_mem_r[rd_ptr_r];
  assign head_cnt   = cnt_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem_r[wr_ptr_r] <= push_ctl;
      sum_mem_r[wr_ptr_r] <= push_sum;
      cnt_mem_r[wr_ptr_r] <= push_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

/* hw/rtl/lcr_back.sv */
// ----------------------------------------------------------------------------
// lcr_back
// Takes requests from the queue, runs a bit-serial restoring divide for
// average ticks and holds each result in the output register.
// ----------------------------------------------------------------------------
module lcr_back import lcr_pkg::*; #(
  parameter int SW = LCR_AVG_W + 8,
  parameter int CW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  output logic                 pop,
  input  lcr_ctl_t             head_ctl,
  input  logic [SW-1:0]        head_sum,
  input  logic [CW-1:0]        head_cnt,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_clock_level,
  output logic                 out_average_valid,
  output logic [LCR_AVG_W-1:0] out_average_value
);

  localparam int IW = (SW > 1) ? $clog2(SW) : 1;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_HOLD} bstate_t;

  bstate_t              state_r;
  logic [SW-1:0]        quo_r;
  logic [CW-1:0]        rem_r;
  logic [CW-1:0]        den_r;
  logic [IW-1:0]        iter_r;
  logic                 out_valid_r;
  logic                 out_clk_r;
  logic                 out_avg_valid_r;
  logic [LCR_AVG_W-1:0] out_value_r;

  logic          out_free;
  logic [CW:0]   trial;
  logic          take;
  logic          load_tick;
  logic          load_avg;

  assign out_free = ~out_valid_r | out_ready;
  assign pop      = (state_r == B_IDLE) & head_valid & (head_ctl.avg_valid | out_free);
  assign trial    = {rem_r, quo_r[SW-1]};
  assign take     = (trial >= {1'b0, den_r});

  assign load_tick = pop & ~head_ctl.avg_valid;
  assign load_avg  = (state_r == B_HOLD) & out_free;

  assign out_valid         = out_valid_r;
  assign out_clock_level   = out_clk_r;
  assign out_average_valid = out_avg_valid_r;
  assign out_average_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= B_IDLE;
      out_valid_r     <= 1'b0;
      iter_r          <= '0;
      out_clk_r       <= 1'b0;
      out_avg_valid_r <= 1'b0;
      out_value_r     <= '0;
    end else begin
      if (load_tick || load_avg) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (pop) begin
            if (head_ctl.avg_valid) begin
              quo_r   <= head_sum;
              rem_r   <= '0;
              den_r   <= head_cnt;
              iter_r  <= '0;
              state_r <= B_DIV;
            end else begin
              out_clk_r       <= head_ctl.clk_level;
              out_avg_valid_r <= 1'b0;
              out_value_r     <= '0;
            end
          end
        end
        B_DIV: begin
          rem_r  <= take ? CW'(trial - {1'b0, den_r}) : trial[CW-1:0];
          quo_r  <= {quo_r[SW-2:0], take};
          iter_r <= iter_r + IW'(1);
          if (iter_r == IW'(SW - 1)) state_r <= B_HOLD;
        end
        B_HOLD: begin
          if (out_free) begin
            out_clk_r       <= 1'b0;
            out_avg_valid_r <= 1'b1;
            out_value_r     <= quo_r[LCR_AVG_W-1:0];
            state_r         <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/load_cell_adc_serial_reader_core.sv */
// A plain tick is written into the queue, then popped into the output register.
// An averaging tick also runs through the one-bit-per-cycle restoring divider.
// Throughput: one tick per cycle between averages, unless out_ready stalls the
// output; the two-entry queue absorbs ticks while the divider runs. Reset
// (sync, active low) clears the sequencer, sum, queue and output;
// extra_pulses and sample_count reset to 1.
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_core
// Serial readout of a two-wire load-cell converter with sample averaging.
// ----------------------------------------------------------------------------
module load_cell_adc_serial_reader_core import lcr_pkg::*; #(
  parameter int DATA_BITS   = LCR_DATA_BITS,
  parameter int MAX_SAMPLES = LCR_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [LCR_IDX_W-1:0] cfg_index,
  input  logic [LCR_CFG_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_data_pin,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_clock_level,
  output logic                 out_average_valid,
  output logic [LCR_AVG_W-1:0] out_average_value
);

  localparam int RW = (DATA_BITS > LCR_AVG_W) ? DATA_BITS : LCR_AVG_W;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = RW + CW;

  logic          q_full, q_push, q_valid, q_pop;
  lcr_ctl_t      q_ctl, h_ctl;
  logic [SW-1:0] q_sum, h_sum;
  logic [CW-1:0] q_cnt, h_cnt;

  lcr_front #(
    .DATA_BITS(DATA_BITS), .MAX_SAMPLES(MAX_SAMPLES), .RW(RW), .CW(CW), .SW(SW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_pin(in_data_pin),
    .q_full(q_full), .q_push(q_push), .q_ctl(q_ctl), .q_sum(q_sum), .q_cnt(q_cnt)
  );

  lcr_queue #(.SW(SW), .CW(CW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_ctl(q_ctl), .push_sum(q_sum), .push_cnt(q_cnt),
    .full(q_full), .head_valid(q_valid), .pop(q_pop),
    .head_ctl(h_ctl), .head_sum(h_sum), .head_cnt(h_cnt)
  );

  lcr_back #(.SW(SW), .CW(CW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .head_valid(q_valid), .pop(q_pop),
    .head_ctl(h_ctl), .head_sum(h_sum), .head_cnt(h_cnt),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_clock_level(out_clock_level),
    .out_average_valid(out_average_valid),
    .out_average_value(out_average_value)
  );

endmodule

/* hw/rtl/lcr_checker.sv */
// ----------------------------------------------------------------------------
// lcr_checker
// Port-level checks on the serial reader, bound to the top level.
// ----------------------------------------------------------------------------
`include "load_cell_adc_serial_reader_core_macros.svh"

module lcr_checker import lcr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_clock_level,
  input logic                 out_average_valid,
  input logic [LCR_AVG_W-1:0] out_average_value
);

  `LCR_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")

  `LCR_ASSERT(a_value_zero, out_valid && !out_average_valid |-> out_average_value == '0, "average value set without valid flag")

  `LCR_ASSERT(a_avg_on_low_tick, out_valid && out_average_valid |-> !out_clock_level, "average on a clock-high tick")

  `LCR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_average_value) && $stable(out_average_valid) && $stable(out_clock_level), "stalled result changed")

endmodule

bind load_cell_adc_serial_reader_core lcr_checker u_lcr_checker (.*);
